/* hw/rtl/rc4_stream_cipher_macros.svh */
// Assertion macros shared by the RC4 cipher RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define RC4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RC4_ASSERT(lbl, prop, msg)
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/rc4_pkg.sv */
// Package for the RC4 stream cipher: sizes, sequencer step codes,
// the microcode table and the permutation memory request type. No dependencies.
package rc4_pkg;

  localparam int unsigned KEY_MAX    = 256;
  localparam int unsigned KEY_AW     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned KEY_CW     = $clog2(KEY_MAX + 1);
  localparam logic [KEY_CW-1:0] KEY_MAX_CNT = KEY_CW'(KEY_MAX);
  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned PERM_AW    = 8;

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_P_INC,
    STEP_P_RDI,
    STEP_P_WRI,
    STEP_P_WRJ,
    STEP_P_RDK,
    STEP_P_EMIT,
    STEP_K_INIT,
    STEP_K_RDI,
    STEP_K_MIX,
    STEP_K_WRI,
    STEP_K_WRJ,
    STEP_K_DONE
  } step_e;

  typedef enum logic [1:0] {RA_I, RA_I_INC, RA_MIX, RA_SUM_AB} raddr_e;
  typedef enum logic [1:0] {I_HOLD, I_CLEAR, I_INC} i_op_e;
  typedef enum logic [1:0] {J_HOLD, J_CLEAR, J_MIX} j_op_e;
  typedef enum logic [1:0] {WR_NONE, WR_I_RD, WR_J_A} wr_e;
  typedef enum logic [1:0] {JMP_NEXT, JMP_IDLE, JMP_LOOP} jmp_e;

  typedef struct packed {
    raddr_e raddr;
    i_op_e  i_op;
    j_op_e  j_op;
    wr_e    wr;
    logic   load_a;
    logic   load_b;
    logic   use_key;
    logic   clr_perm;
    logic   kp_clear;
    logic   clr_count;
    logic   emit;
    jmp_e   jmp;
    step_e  target;
  } ucode_t;

  typedef struct packed {
    logic               clr;
    logic               we;
    logic [PERM_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [PERM_AW-1:0] raddr;
  } perm_req_t;

  // Control store. Each read issued in one step returns its data in the next.
  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    w = '0;
    unique case (s)
      STEP_IDLE: w.jmp = JMP_IDLE;
      STEP_P_INC: begin
        w.raddr = RA_I_INC;
        w.i_op  = I_INC;
      end
      STEP_P_RDI: begin
        w.load_a = 1'b1;
        w.j_op   = J_MIX;
        w.raddr  = RA_MIX;
      end
      STEP_P_WRI: begin
        w.load_b = 1'b1;
        w.wr     = WR_I_RD;
      end
      STEP_P_WRJ: w.wr = WR_J_A;
      STEP_P_RDK: w.raddr = RA_SUM_AB;
      // The keystream read is repeated so its data survives an output stall.
      STEP_P_EMIT: begin
        w.raddr = RA_SUM_AB;
        w.emit  = 1'b1;
        w.jmp   = JMP_IDLE;
      end
      STEP_K_INIT: begin
        w.clr_perm = 1'b1;
        w.i_op     = I_CLEAR;
        w.j_op     = J_CLEAR;
        w.kp_clear = 1'b1;
      end
      STEP_K_RDI: w.raddr = RA_I;
      STEP_K_MIX: begin
        w.load_a  = 1'b1;
        w.j_op    = J_MIX;
        w.use_key = 1'b1;
        w.raddr   = RA_MIX;
      end
      STEP_K_WRI: begin
        w.load_b = 1'b1;
        w.wr     = WR_I_RD;
      end
      STEP_K_WRJ: begin
        w.wr     = WR_J_A;
        w.i_op   = I_INC;
        w.jmp    = JMP_LOOP;
        w.target = STEP_K_RDI;
      end
      STEP_K_DONE: begin
        w.i_op      = I_CLEAR;
        w.j_op      = J_CLEAR;
        w.clr_count = 1'b1;
        w.jmp       = JMP_IDLE;
      end
      default: w.jmp = JMP_IDLE;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/rc4_perm_ram.sv */
// Permutation memory of the RC4 cipher: 256 bytes, one write and one read
// per cycle, registered read. Depends on rc4_pkg.
module rc4_perm_ram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rc4_pkg::perm_req_t             req_i,
  output logic [7:0]                     rdata_o
);

  logic [7:0]                       mem_q [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::PERM_DEPTH-1:0]   valid_q;
  logic [7:0]                       rd_q;
  logic                             rd_valid_q;
  logic [rc4_pkg::PERM_AW-1:0]      rd_addr_q;

  // An entry not written since the last clear holds its own address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q       <= mem_q[req_i.raddr];
    rd_valid_q <= valid_q[req_i.raddr];
    rd_addr_q  <= req_i.raddr;
  end

  assign rdata_o = rd_valid_q ? rd_q : rd_addr_q;

endmodule

/* hw/rtl/rc4_stream_cipher.sv */
// Top level of the RC4 stream cipher: microcoded sequencer, key store,
// output register. Depends on rc4_pkg, rc4_perm_ram and the assertion macros.
//
// Usage. Requests enter on the slave stream. tuser[0] selects the kind:
// 0 loads a key byte from tdata, 1 encrypts or decrypts the byte in tdata.
// On a key byte tuser[1] marks the final key byte, which appends it and then
// runs the key schedule. On a data byte tlast marks the end of a message and
// is copied to the master tlast of its result; the keystream carries on.
// A key byte is taken at the idle step and gives no result. A data byte gives
// exactly one result, and the next request is taken only after the data byte
// has run six microcode steps, set by the single read port of the permutation
// memory, and returned to the idle step that takes the request.
// The final key byte keeps tready low during the key schedule: 256 schedule
// steps of four microcode steps each on the same memory, plus setup and wrap-up.
// Key bytes beyond 256 are dropped; the schedule then uses the stored 256.
// Reset clears the indices and key count and marks the whole permutation as
// identity at once through per-entry valid bits, so no clearing pass is run.
// A result waits in the output register while the receiver stalls; the
// sequencer only stops at its last step if that register is still full.
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser,   // [0] action, [1] last_key
  input  logic       s_axis_tlast,   // message_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);

  rc4_pkg::step_e                 step_q, step_d;
  rc4_pkg::ucode_t                uc;
  rc4_pkg::perm_req_t             perm_req;

  logic [7:0]                     i_q, i_d;
  logic [7:0]                     j_q, j_d;
  logic [7:0]                     a_q, b_q;
  logic [7:0]                     byte_q;
  logic                           end_q;
  logic [rc4_pkg::KEY_CW-1:0]     key_count_q, key_count_d;
  logic [rc4_pkg::KEY_AW-1:0]     kp_q, kp_d;
  logic [7:0]                     key_mem_q [rc4_pkg::KEY_MAX];
  logic [7:0]                     key_rd_q;

  logic                           out_valid_q;
  logic [7:0]                     out_byte_q;
  logic                           out_last_q;

  logic                           in_acc;
  logic                           data_acc;
  logic                           key_we;
  logic                           out_free;
  logic                           out_load;
  logic [7:0]                     perm_rd;
  logic [7:0]                     mix_sum;
  logic [rc4_pkg::KEY_CW-1:0]     key_len;
  logic [rc4_pkg::KEY_CW-1:0]     kp_inc;

  // A request is taken only at the idle step.
  assign s_axis_tready = (step_q == rc4_pkg::STEP_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign data_acc      = in_acc && s_axis_tuser[0];
  assign key_we        = in_acc && !s_axis_tuser[0] && (key_count_q != rc4_pkg::KEY_MAX_CNT);

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || m_axis_tready;
  assign uc       = rc4_pkg::ucode_rom(step_q);
  assign out_load = uc.emit && out_free;

  // Next step: dispatch from idle, hold at the emit step on a stall, else
  // follow the jump field of the control word.
  always_comb begin
    step_d = step_q;
    if (step_q == rc4_pkg::STEP_IDLE) begin
      if (in_acc) begin
        if (s_axis_tuser[0]) begin
          step_d = rc4_pkg::STEP_P_INC;
        end else if (s_axis_tuser[1]) begin
          step_d = rc4_pkg::STEP_K_INIT;
        end
      end
    end else if (uc.emit && !out_free) begin
      step_d = step_q;
    end else begin
      unique case (uc.jmp)
        rc4_pkg::JMP_NEXT: step_d = rc4_pkg::step_e'(step_q + 4'd1);
        rc4_pkg::JMP_IDLE: step_d = rc4_pkg::STEP_IDLE;
        rc4_pkg::JMP_LOOP: begin
          if (i_q == 8'hFF) begin
            step_d = rc4_pkg::step_e'(step_q + 4'd1);
          end else begin
            step_d = uc.target;
          end
        end
        default: step_d = rc4_pkg::STEP_IDLE;
      endcase
    end
  end

  // Datapath driven by the control word.
  assign mix_sum = j_q + perm_rd + (uc.use_key ? key_rd_q : 8'd0);
  assign key_len = (key_count_q == '0) ? rc4_pkg::KEY_CW'(1) : key_count_q;
  assign kp_inc  = {1'b0, kp_q} + rc4_pkg::KEY_CW'(1);

  always_comb begin
    perm_req.clr   = uc.clr_perm;
    perm_req.we    = 1'b0;
    perm_req.waddr = i_q;
    perm_req.wdata = perm_rd;
    case (uc.wr)
      rc4_pkg::WR_I_RD: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = i_q;
        perm_req.wdata = perm_rd;
      end
      rc4_pkg::WR_J_A: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_q;
        perm_req.wdata = a_q;
      end
      default: perm_req.we = 1'b0;
    endcase
    case (uc.raddr)
      rc4_pkg::RA_I:      perm_req.raddr = i_q;
      rc4_pkg::RA_I_INC:  perm_req.raddr = i_q + 8'd1;
      rc4_pkg::RA_MIX:    perm_req.raddr = mix_sum;
      rc4_pkg::RA_SUM_AB: perm_req.raddr = a_q + b_q;
      default:            perm_req.raddr = i_q;
    endcase
  end

  always_comb begin
    case (uc.i_op)
      rc4_pkg::I_CLEAR: i_d = 8'd0;
      rc4_pkg::I_INC:   i_d = i_q + 8'd1;
      default:          i_d = i_q;
    endcase
    case (uc.j_op)
      rc4_pkg::J_CLEAR: j_d = 8'd0;
      rc4_pkg::J_MIX:   j_d = mix_sum;
      default:          j_d = j_q;
    endcase
    // The key pointer wraps at the stored key length.
    kp_d = kp_q;
    if (uc.kp_clear) begin
      kp_d = '0;
    end else if (uc.use_key) begin
      kp_d = (kp_inc == key_len) ? '0 : kp_inc[rc4_pkg::KEY_AW-1:0];
    end
    key_count_d = key_count_q;
    if (uc.clr_count) begin
      key_count_d = '0;
    end else if (key_we) begin
      key_count_d = key_count_q + rc4_pkg::KEY_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= rc4_pkg::STEP_IDLE;
      i_q         <= 8'd0;
      j_q         <= 8'd0;
      kp_q        <= '0;
      key_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      i_q         <= i_d;
      j_q         <= j_d;
      kp_q        <= kp_d;
      key_count_q <= key_count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= s_axis_tdata;
      end_q  <= s_axis_tlast;
    end
    if (uc.load_a) begin
      a_q <= perm_rd;
    end
    if (uc.load_b) begin
      b_q <= perm_rd;
    end
    if (out_load) begin
      out_byte_q <= byte_q ^ perm_rd;
      out_last_q <= end_q;
    end
  end

  // Key store: appended at the fill count, read through the key pointer.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem_q[key_count_q[rc4_pkg::KEY_AW-1:0]] <= s_axis_tdata;
    end
    key_rd_q <= key_mem_q[kp_q];
  end

  rc4_perm_ram u_perm_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (perm_req),
    .rdata_o (perm_rd)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  `RC4_ASSERT_NEXT(a_data_starts, data_acc, step_q == rc4_pkg::STEP_P_INC, "data not started")
  `RC4_ASSERT(a_key_count_max, key_count_q <= rc4_pkg::KEY_MAX_CNT, "key count overflow")
  `RC4_ASSERT_NEXT(a_emit_hold, uc.emit && !out_free, uc.emit, "emit step left during stall")
  `RC4_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(uc.emit), "result without emit")

endmodule

/* bench/tb_rc4_stream_cipher.sv */
// Self-checking testbench for the RC4 stream cipher top level rc4_stream_cipher.
// Depends on rc4_pkg and the RTL; a built-in RC4 predictor checks every result.

module tb_rc4_stream_cipher;

  // Request kinds carried in tuser[0].
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  // The run is stopped as failed after this many clock cycles. It stays well
  // above a run in which every request is a final key byte under full stalls.
  localparam int CYCLE_LIMIT = 10_000_000;
  // After the last request a key schedule may still be running, so the bench
  // keeps watching the output after the last expected result.
  localparam int DRAIN_CYCLES = 1100;
  // Neither side idles while the accepted-request count is in this window.
  localparam int STEADY_LO = 600;
  localparam int STEADY_HI = 900;
  localparam int IDLE_PCT  = 21;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last_key;
    logic       message_end;
  } cipher_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } cipher_res_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] data_byte
  logic [1:0] s_axis_tuser  = 2'b00;  // [0] action, [1] last_key
  logic       s_axis_tlast  = 1'b0;   // message_end
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;           // out_last

  rc4_stream_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predictor state: permutation, key store, key length and both indices.
  logic [7:0]  sbox [256];
  logic [7:0]  key_mem [rc4_pkg::KEY_MAX];
  int          key_len;
  logic [7:0]  idx_i;
  logic [7:0]  idx_j;

  cipher_req_t pending_req_q[$];
  cipher_res_t expected_out_q[$];
  cipher_req_t held_req;
  int          n_total    = 0;
  int          n_accepted = 0;
  int          n_errors   = 0;
  int          n_cycles   = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Applies one accepted request to the predictor state and queues the
  // result that a data byte produces. Key bytes produce nothing.
  task automatic rc4_predict(input cipher_req_t r);
    int         n;
    logic [7:0] acc;
    logic [7:0] tmp;
    logic [7:0] sel;
    if (r.action == ACT_KEY) begin
      // Bytes beyond a full key store are dropped.
      if (key_len < rc4_pkg::KEY_MAX) begin
        key_mem[key_len] = r.data_byte;
        key_len++;
      end
      if (r.last_key) begin
        n = (key_len == 0) ? 1 : key_len;
        for (int k = 0; k < 256; k++) sbox[k] = 8'(k);
        idx_i = '0;
        idx_j = '0;
        acc   = '0;
        for (int k = 0; k < 256; k++) begin
          acc       = acc + sbox[k] + key_mem[k % n];
          tmp       = sbox[k];
          sbox[k]   = sbox[acc];
          sbox[acc] = tmp;
        end
        key_len = 0;
      end
    end else begin
      idx_i       = idx_i + 8'd1;
      idx_j       = idx_j + sbox[idx_i];
      tmp         = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = tmp;
      sel         = sbox[idx_i] + sbox[idx_j];
      expected_out_q.push_back('{out_byte: r.data_byte ^ sbox[sel],
                                 out_last: r.message_end});
    end
  endtask

  task automatic add_req(input logic act, input logic [7:0] b, input logic lk,
                         input logic me);
    pending_req_q.push_back('{action: act, data_byte: b, last_key: lk, message_end: me});
  endtask

  // Request driver. The held request is predicted at the edge that accepts it;
  // the next one is put on the bus in the same step unless the sender idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tuser  <= 2'b00;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rc4_predict(held_req);
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_req_q.size() != 0 &&
            ((n_accepted >= STEADY_LO && n_accepted < STEADY_HI) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          held_req = pending_req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= held_req.data_byte;
          s_axis_tuser  <= {held_req.last_key, held_req.action};
          s_axis_tlast  <= held_req.message_end;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random receiver stalls, plus the run-time limit.
  always @(posedge clk_i or negedge rst_ni) begin
    cipher_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result byte %02h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_out_q.pop_front();
          if (m_axis_tdata !== want.out_byte) begin
            n_errors++;
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.out_byte, m_axis_tdata);
          end
          if (m_axis_tlast !== want.out_last) begin
            n_errors++;
            $display("%0t: out_last expected %b actual %b",
                     $time, want.out_last, m_axis_tlast);
          end
        end
      end
      m_axis_tready <= (n_accepted >= STEADY_LO && n_accepted < STEADY_HI) ||
                       ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int klen;
    int nmsg;
    int mlen;
    int n_gen;
    int seq;

    for (int k = 0; k < 256; k++) sbox[k] = 8'(k);
    for (int k = 0; k < rc4_pkg::KEY_MAX; k++) key_mem[k] = 8'h00;
    key_len = 0;
    idx_i   = '0;
    idx_j   = '0;

    // Data before any key runs on the identity permutation. A last_key flag
    // on a data byte must be ignored.
    add_req(ACT_DATA, 8'h00, 1'b0, 1'b0);
    add_req(ACT_DATA, 8'hFF, 1'b0, 1'b0);
    add_req(ACT_DATA, 8'h80, 1'b0, 1'b1);
    add_req(ACT_DATA, 8'h01, 1'b1, 1'b0);
    // A three-byte key; message_end on a key byte must be ignored.
    add_req(ACT_KEY, 8'h00, 1'b0, 1'b1);
    add_req(ACT_KEY, 8'hFF, 1'b0, 1'b0);
    add_req(ACT_KEY, 8'h5A, 1'b1, 1'b0);
    add_req(ACT_DATA, 8'hFF, 1'b0, 1'b0);
    add_req(ACT_DATA, 8'h00, 1'b0, 1'b0);
    add_req(ACT_DATA, 8'h7F, 1'b0, 1'b1);
    // The keystream carries on across the end of a message.
    add_req(ACT_DATA, 8'h55, 1'b1, 1'b0);
    add_req(ACT_DATA, 8'hAA, 1'b0, 1'b1);
    // One-byte keys at both extremes.
    add_req(ACT_KEY, 8'hFF, 1'b1, 1'b1);
    add_req(ACT_DATA, 8'h00, 1'b0, 1'b0);
    add_req(ACT_DATA, 8'hFF, 1'b0, 1'b1);
    add_req(ACT_KEY, 8'h00, 1'b1, 1'b0);
    add_req(ACT_DATA, 8'h00, 1'b0, 1'b0);
    add_req(ACT_DATA, 8'h00, 1'b0, 1'b1);

    // Random part: mostly a key followed by a few messages, with some noise
    // and broken sequences mixed in. The first key overflows the key store.
    n_gen = 0;
    seq   = 0;
    while (n_gen < 2000) begin
      if (seq == 0 || $urandom_range(99) < 85) begin
        if (seq == 0) klen = rc4_pkg::KEY_MAX + 1;
        else if ($urandom_range(11) == 0)
          klen = $urandom_range(rc4_pkg::KEY_MAX + 4, rc4_pkg::KEY_MAX - 2);
        else klen = $urandom_range(32, 1);
        for (int k = 0; k < klen; k++)
          add_req(ACT_KEY, 8'($urandom()), k == klen - 1, $urandom_range(7) == 0);
        n_gen += klen;
        nmsg = $urandom_range(3, 1);
        for (int m = 0; m < nmsg; m++) begin
          mlen = $urandom_range(40, 1);
          for (int k = 0; k < mlen; k++)
            add_req(ACT_DATA, 8'($urandom()), $urandom_range(9) == 0, k == mlen - 1);
          n_gen += mlen;
        end
      end else begin
        // Noise: any mix of kinds and flags, including key bytes that are
        // never closed and so extend the next key.
        mlen = $urandom_range(6, 1);
        for (int k = 0; k < mlen; k++)
          add_req(1'($urandom()), 8'($urandom()), $urandom_range(3) == 0,
                  1'($urandom()));
        n_gen += mlen;
      end
      seq++;
    end
    n_total = pending_req_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total || expected_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_perm_ram.sv
hw/rtl/rc4_stream_cipher.sv
bench/tb_rc4_stream_cipher.sv
